[rtl/core/llca_pkg.sv]
// ---------------------------------------------------------------------------
// llca_pkg: shared constants of the least-loaded CPU allocator
// Default sizes, operation and status codes, configuration register
// indexes and the stream payload layout.
// ---------------------------------------------------------------------------
package llca_pkg;

    // Default sizes
    localparam int CPUS_DEF        = 64;
    localparam int NODES_DEF       = 4;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int MASK_W     = 64;
    localparam int REQ_CNT_W  = 7;
    localparam int NODE_ID_W  = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    // Slave tdata layout, lowest bit first
    localparam int S_COUNT_LSB = 0;
    localparam int S_BOUND_LSB = S_COUNT_LSB + REQ_CNT_W;
    localparam int S_NODE_LSB  = S_BOUND_LSB + 1;
    localparam int S_OLD_LSB   = S_NODE_LSB + NODE_ID_W;
    localparam int S_NEW_LSB   = S_OLD_LSB + MASK_W;
    localparam int S_USED_W    = S_NEW_LSB + MASK_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = MASK_W;

    // Operation codes (s_axis_tuser)
    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Status codes (m_axis_tuser)
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_HOST_MASK = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_LOW   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_HIGH  = 2'd2;

endpackage

[rtl/core/llca_ram.sv]
// ---------------------------------------------------------------------------
// llca_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module llca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/least_loaded_cpu_allocator.sv]
// ---------------------------------------------------------------------------
// least_loaded_cpu_allocator: least-loaded CPU picker with usage counters
//
// Slave stream takes one request per transfer: tuser is the operation
// (allocate or update), tdata carries count, node_bound, node_id, old_mask
// and new_mask. Master stream returns one result per request: tdata is the
// CPU mask, tuser the status (fail means the allocation was rolled back).
// Configuration writes (online mask, node maps) go through i_cfg_we,
// i_cfg_addr and i_cfg_wdata and take effect at the next edge.
// Per-CPU usage lives in a RAM; one shared compare unit scans it one CPU
// per cycle. An allocate of k CPUs runs a scan and a pick step for each
// CPU; a failing pick ends its scan in a rollback pass in place of the
// pick step. An update runs one pass over the usage RAM. s_axis_tready is
// high only while the block is idle, so one request is in work at a time
// and the next one can be taken as soon as the result appears.
// After reset the usage RAM is cleared, during which no request is taken;
// configuration writes are taken at all times.
// When the receiver stalls, the finished result waits in the output
// register and the block holds its last step until the register frees.
// ---------------------------------------------------------------------------
module least_loaded_cpu_allocator
    import llca_pkg::*;
#(
    parameter int CPUS        = CPUS_DEF,
    parameter int NODES       = NODES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: count[6:0], node_bound[7], node_id[9:8], old_mask[73:10],
    //        new_mask[137:74], zero pad[143:138]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation[0]
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: cpu_mask[63:0]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: status[0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CPU_W  = $clog2(CPUS);
    localparam int CNT_W  = $clog2(CPUS + 1);
    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW     = COUNT_WIDTH;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_PICK  = 3'd3;
    localparam logic [2:0] ST_APPLY = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    function automatic logic [CW-1:0] sat_bump(input logic [CW-1:0] v, input logic up);
        logic [CW-1:0] res;
        res = v;
        if (up) begin
            if (v != {CW{1'b1}}) res = v + CW'(1);
        end else begin
            if (v != '0) res = v - CW'(1);
        end
        return res;
    endfunction

    function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_ID_W-1:0] raw);
        logic [NODE_W-1:0] res;
        if ({1'b0, raw} >= 3'(NODES)) res = NODE_W'(NODES - 1);
        else                          res = NODE_W'(raw);
        return res;
    endfunction

    // Control state
    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_dv, n_dv;
    logic              r_found, n_found;
    logic [CPU_W-1:0]  r_didx, n_didx;
    logic [CPU_W-1:0]  r_best, n_best;
    logic [CW-1:0]     r_bc, n_bc;
    logic [CW-1:0]     r_bn, n_bn;
    logic [CPUS-1:0]   r_picked, n_picked;
    logic [CPUS-1:0]   r_from, n_from;
    logic [CPUS-1:0]   r_to, n_to;
    logic [REQ_CNT_W-1:0] r_left, n_left;
    logic              r_op, n_op;
    logic              r_bound, n_bound;
    logic [NODE_W-1:0] r_node, n_node;
    logic [MASK_W-1:0] r_new_mask, n_new_mask;
    logic              r_fail, n_fail;
    logic              r_m_valid, n_m_valid;
    logic [MASK_W-1:0] r_m_mask, n_m_mask;
    logic              r_m_status, n_m_status;

    // Configuration and counters
    logic [CFG_DATA_W-1:0] r_host, r_map_lo, r_map_hi;
    logic [CW-1:0]     r_node_use [NODES];
    logic [CW-1:0]     n_node_use [NODES];
    logic [CW-1:0]     r_node_req [NODES];
    logic [CW-1:0]     n_node_req [NODES];
    logic [CW-1:0]     r_unb, n_unb;

    // Datapath signals
    logic [2*CFG_DATA_W-1:0] map_all;
    logic [CPU_W-1:0]  node_cpu;
    logic [NODE_W-1:0] cur_node;
    logic [CW-1:0]     ram_q;
    logic [CW-1:0]     cur_un;
    logic [CW-1:0]     cur_req;
    logic              eligible;
    logic              better;
    logic              acc_en;
    logic              acc_up;
    logic              ram_we;
    logic [CPU_W-1:0]  ram_waddr;
    logic [CW-1:0]     ram_wdata;
    logic              scan_end;
    logic              in_xfer;

    llca_ram #(
        .WIDTH (CW),
        .DEPTH (CPUS)
    ) u_usage_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[CPU_W-1:0]),
        .o_rdata (ram_q)
    );

    // Node lookup of the CPU under work and compare unit
    assign map_all  = {r_map_hi, r_map_lo};
    assign node_cpu = (r_state == ST_PICK) ? r_best : r_didx;
    assign cur_node = clamp_node(map_all[{node_cpu, 1'b0} +: NODE_ID_W]);
    assign cur_un   = r_node_use[cur_node];
    assign cur_req  = r_bound ? r_node_req[r_node] : r_unb;
    assign eligible = !r_picked[r_didx] && (!r_bound || (cur_node == r_node));
    assign better   = !r_found || ({ram_q, cur_un} < {r_bc, r_bn});
    assign scan_end = (r_cnt == CNT_W'(CPUS)) && !r_dv;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_mask;
    assign m_axis_tuser  = r_m_status;

    // Counter update and RAM write selection
    always_comb begin
        acc_en    = 1'b0;
        acc_up    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_didx;
        ram_wdata = sat_bump(ram_q, r_to[r_didx]);
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[CPU_W-1:0];
                ram_wdata = '0;
            end
            ST_PICK: begin
                acc_en    = 1'b1;
                acc_up    = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = r_best;
                ram_wdata = sat_bump(r_bc, 1'b1);
            end
            ST_APPLY: begin
                acc_en = r_dv && (r_from[r_didx] != r_to[r_didx]);
                acc_up = r_to[r_didx];
                ram_we = acc_en;
            end
            default: begin
                acc_en = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_dv       = 1'b0;
        n_didx     = r_cnt[CPU_W-1:0];
        n_found    = r_found;
        n_best     = r_best;
        n_bc       = r_bc;
        n_bn       = r_bn;
        n_picked   = r_picked;
        n_from     = r_from;
        n_to       = r_to;
        n_left     = r_left;
        n_op       = r_op;
        n_bound    = r_bound;
        n_node     = r_node;
        n_new_mask = r_new_mask;
        n_fail     = r_fail;
        n_m_valid  = r_m_valid;
        n_m_mask   = r_m_mask;
        n_m_status = r_m_status;
        n_node_use = r_node_use;
        n_node_req = r_node_req;
        n_unb      = r_unb;

        // Drop the result once the receiver takes it
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        // Bump node and request counters of the CPU under work
        if (acc_en) begin
            n_node_use[cur_node] = sat_bump(cur_un, acc_up);
            if (r_bound) n_node_req[r_node] = sat_bump(cur_req, acc_up);
            else         n_unb = sat_bump(cur_req, acc_up);
        end

        case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CPUS - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_op       = s_axis_tuser;
                    n_bound    = s_axis_tdata[S_BOUND_LSB];
                    n_node     = clamp_node(s_axis_tdata[S_NODE_LSB +: NODE_ID_W]);
                    n_new_mask = s_axis_tdata[S_NEW_LSB +: MASK_W];
                    n_left     = s_axis_tdata[S_COUNT_LSB +: REQ_CNT_W];
                    n_picked   = '0;
                    n_fail     = 1'b0;
                    n_found    = 1'b0;
                    n_cnt      = '0;
                    if (s_axis_tuser == OP_UPDATE) begin
                        n_from  = s_axis_tdata[S_OLD_LSB +: CPUS];
                        n_to    = s_axis_tdata[S_NEW_LSB +: CPUS];
                        n_state = ST_APPLY;
                    end else if (s_axis_tdata[S_COUNT_LSB +: REQ_CNT_W] == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Issue the next read
                if (r_cnt != CNT_W'(CPUS)) begin
                    n_dv  = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                end
                // Keep the smallest (cpu usage, node usage) so far
                if (r_dv && eligible && better) begin
                    n_found = 1'b1;
                    n_best  = r_didx;
                    n_bc    = ram_q;
                    n_bn    = cur_un;
                end
                if (scan_end) begin
                    n_cnt = '0;
                    if (!r_found || !r_host[r_best]) begin
                        n_from  = r_picked;
                        n_to    = '0;
                        n_fail  = 1'b1;
                        n_state = ST_APPLY;
                    end else begin
                        n_state = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                n_picked[r_best] = 1'b1;
                n_left           = r_left - REQ_CNT_W'(1);
                n_found          = 1'b0;
                n_cnt            = '0;
                n_state          = (r_left == REQ_CNT_W'(1)) ? ST_DONE : ST_SCAN;
            end
            ST_APPLY: begin
                if (r_cnt != CNT_W'(CPUS)) begin
                    n_dv  = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (scan_end) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the output register when it is free
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_fail ? STAT_FAIL : STAT_OK;
                    if (r_op == OP_UPDATE) n_m_mask = r_new_mask;
                    else if (r_fail)       n_m_mask = '0;
                    else                   n_m_mask = MASK_W'(r_picked);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_dv       <= 1'b0;
            r_found    <= 1'b0;
            r_m_valid  <= 1'b0;
            r_host     <= '0;
            r_map_lo   <= '0;
            r_map_hi   <= '0;
            r_unb      <= '0;
            for (int n = 0; n < NODES; n++) begin
                r_node_use[n] <= '0;
                r_node_req[n] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_dv       <= n_dv;
            r_found    <= n_found;
            r_m_valid  <= n_m_valid;
            r_node_use <= n_node_use;
            r_node_req <= n_node_req;
            r_unb      <= n_unb;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_HOST_MASK: r_host   <= i_cfg_wdata;
                    CFG_MAP_LOW:   r_map_lo <= i_cfg_wdata;
                    CFG_MAP_HIGH:  r_map_hi <= i_cfg_wdata;
                    default:       r_host   <= r_host;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_didx     <= n_didx;
        r_best     <= n_best;
        r_bc       <= n_bc;
        r_bn       <= n_bn;
        r_picked   <= n_picked;
        r_from     <= n_from;
        r_to       <= n_to;
        r_left     <= n_left;
        r_op       <= n_op;
        r_bound    <= n_bound;
        r_node     <= n_node;
        r_new_mask <= n_new_mask;
        r_fail     <= n_fail;
        r_m_mask   <= n_m_mask;
        r_m_status <= n_m_status;
    end

`ifndef SYNTHESIS
    // The read counter never runs past the CPU count while scanning
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_APPLY) |-> (r_cnt <= CNT_W'(CPUS)))
        else $error("scan counter out of range");

    // Read data is only in flight during a scan or an apply pass
    a_dv_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == ST_SCAN || r_state == ST_APPLY))
        else $error("read data outside a scan");

    // A committed pick is a fresh, online CPU
    a_pick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PICK) |-> (r_found && !r_picked[r_best] && r_host[r_best]))
        else $error("bad pick committed");

    // A failed allocation returns an empty mask
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == STAT_FAIL)) |-> (m_axis_tdata == '0))
        else $error("failure with nonzero mask");

    // No request is taken in the first cycle after reset (RAM clear)
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("request taken during clear");
`endif

endmodule
